### rtl/sca_pkg.sv
// Shared constants and types of the scanline coverage accumulator.
package sca_pkg;

	localparam int MAX_ROW_WIDTH = 64;
	localparam int STORE_DEPTH   = MAX_ROW_WIDTH + 2;
	localparam int STORE_AW      = $clog2(STORE_DEPTH);
	localparam int DELTA_W       = 12;
	localparam int COORD_W       = 21;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int COL_W         = 6;
	localparam int ROW_W         = 16;
	localparam int ALPHA_W       = 8;
	localparam int MODE_W        = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_CROSSING = 2'd0,
		MODE_SCAN_END = 2'd1,
		MODE_FLUSH    = 2'd2,
		MODE_UNUSED   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LG_X      = 3'd0,
		REG_LG_Y      = 3'd1,
		REG_EVEN_ODD  = 3'd2,
		REG_ORIGIN_X  = 3'd3,
		REG_ORIGIN_Y  = 3'd4,
		REG_ROW_WIDTH = 3'd5
	} cfg_reg_t;

endpackage

### rtl/sca_if.sv
// Handshake channel interfaces: input items, result items and configuration writes.
interface sca_in_if;
	logic                                     valid;
	logic                                     ready;
	logic [sca_pkg::MODE_W-1:0]               mode;
	logic signed [sca_pkg::COORD_W-1:0]       crossing_x;
	logic                                     crossing_up;
	logic signed [sca_pkg::COORD_W-1:0]       scanline_y;

	modport source (output valid, mode, crossing_x, crossing_up, scanline_y, input ready);
	modport sink (input valid, mode, crossing_x, crossing_up, scanline_y, output ready);
endinterface

interface sca_out_if;
	logic                           valid;
	logic                           ready;
	logic [sca_pkg::ALPHA_W-1:0]    alpha;
	logic [sca_pkg::COL_W-1:0]      pixel_column;
	logic [sca_pkg::ROW_W-1:0]      pixel_row;
	logic                           last_in_row;

	modport source (output valid, alpha, pixel_column, pixel_row, last_in_row, input ready);
	modport sink (input valid, alpha, pixel_column, pixel_row, last_in_row, output ready);
endinterface

interface sca_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sca_pkg::CFG_IDX_W-1:0]    index;
	logic [sca_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/sca_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sca_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 66
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/scanline_coverage_accumulator_top.sv
// Scanline coverage accumulator: winding tracking, span deltas and row alpha emission.
// Crossings outside the shape, words that emit nothing and mode 3 stay in idle. An inside
// crossing is clipped and made window-relative, stopping if its clipped span is empty; else it
// makes 2 or 4 delta updates, each a read-modify-write through the one read port of the delta
// store. A row emission reads, accumulates and forms the alpha of each pixel, held while the
// result side stalls. Reset (arst_n low) restores the default registers, zeroes the winding
// count and marks every delta entry empty at once through per-entry valid bits; no clear sweep.
module scanline_coverage_accumulator_top (
	input  logic       clk,
	input  logic       arst_n,
	sca_cfg_if.sink    cfg,
	sca_in_if.sink     din,
	sca_out_if.source  dout
);

	// One-hot sequencer states.
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CLIP  = 9'b000000010,
		ST_REL   = 9'b000000100,
		ST_PLAN  = 9'b000001000,
		ST_RD    = 9'b000010000,
		ST_WR    = 9'b000100000,
		ST_E_RD  = 9'b001000000,
		ST_E_ACC = 9'b010000000,
		ST_E_OUT = 9'b100000000
	} state_t;

	localparam int AW    = sca_pkg::STORE_AW;
	localparam int DW    = sca_pkg::DELTA_W;
	localparam int XW    = sca_pkg::COORD_W + 1;   // clip arithmetic, holds right edge
	localparam int RW    = 11;                     // window-relative subpixel x, up to 1024
	localparam int ACC_W = 19;                     // prefix sum of 64 signed 12-bit deltas

	state_t state_q;

	// Configuration registers, raw as written.
	logic [2:0]  lg_x_q;
	logic [2:0]  lg_y_q;
	logic        even_odd_q;
	logic [15:0] origin_x_q;
	logic [15:0] origin_y_q;
	logic [6:0]  row_width_q;

	// Scanline state.
	logic [15:0]                       winding_q;
	logic signed [sca_pkg::COORD_W-1:0] prev_x_q;

	// Crossing datapath.
	logic signed [XW-1:0] x0_q;
	logic signed [XW-1:0] x1_q;
	logic [RW-1:0]        r0_q;
	logic [RW-1:0]        r1_q;
	logic [AW-1:0]        upd_addr_q [4];
	logic [DW-1:0]        upd_amt_q [4];
	logic [2:0]           upd_cnt_q;

	// Delta store bookkeeping.
	logic [sca_pkg::STORE_DEPTH-1:0] vld_q;
	logic                            rd_vld_q;
	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [DW-1:0]                   ram_wdata;
	logic [AW-1:0]                   ram_raddr;
	logic [DW-1:0]                   ram_rdata;
	logic [DW-1:0]                   rd_eff;

	// Emission datapath.
	logic [sca_pkg::COL_W-1:0]   pix_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic [sca_pkg::ROW_W-1:0]   row_q;

	// Result register.
	logic                        out_vld_q;
	logic [sca_pkg::ALPHA_W-1:0] out_alpha_q;
	logic [sca_pkg::COL_W-1:0]   out_col_q;
	logic [sca_pkg::ROW_W-1:0]   out_row_q;
	logic                        out_last_q;

	// Effective configuration: shifts saturate at 4, width clamps to 1..MAX_ROW_WIDTH.
	logic [2:0]           lgx;
	logic [2:0]           lgy;
	logic [6:0]           width;
	logic [3:0]           lg_sum;
	logic [8:0]           maxa;
	logic [3:0]           mask_y;
	logic signed [XW-1:0] left;
	logic signed [XW-1:0] right;
	logic [10:0]          span_w;

	assign lgx    = (lg_x_q > 3'd4) ? 3'd4 : lg_x_q;
	assign lgy    = (lg_y_q > 3'd4) ? 3'd4 : lg_y_q;
	assign width  = (row_width_q == 7'd0) ? 7'd1 :
		((row_width_q > 7'(sca_pkg::MAX_ROW_WIDTH)) ? 7'(sca_pkg::MAX_ROW_WIDTH) : row_width_q);
	assign lg_sum = {1'b0, lgx} + {1'b0, lgy};
	assign maxa   = 9'd1 << lg_sum;
	assign mask_y = 4'((5'd1 << lgy) - 5'd1);
	assign left   = {{(XW-16){origin_x_q[15]}}, origin_x_q} <<< lgx;
	assign span_w = {4'd0, width} << lgx;
	assign right  = left + $signed({{(XW-11){1'b0}}, span_w});

	// Input word decode.
	sca_pkg::mode_t in_mode;
	logic           in_shape;
	logic           on_last;
	logic           do_emit;
	logic signed [sca_pkg::COORD_W-1:0] y_shr;

	assign in_mode  = sca_pkg::mode_t'(din.mode);
	assign in_shape = even_odd_q ? winding_q[0] : (winding_q != 16'd0);
	assign on_last  = ((din.scanline_y[3:0] & mask_y) == mask_y);
	assign do_emit  = ((in_mode == sca_pkg::MODE_SCAN_END) && on_last) ||
		((in_mode == sca_pkg::MODE_FLUSH) && !on_last);
	assign y_shr    = din.scanline_y >>> lgy;

	logic din_acc;
	logic dout_take;
	logic out_free;
	logic out_load;

	assign din.ready = (state_q == ST_IDLE);
	assign din_acc   = din.valid && din.ready;
	assign dout_take = out_vld_q && dout.ready;
	assign out_free  = !out_vld_q || dout.ready;
	assign out_load  = (state_q == ST_E_OUT) && out_free;
	assign cfg.ready = 1'b1;

	// Update plan for one clipped span: either a single pixel (two entries)
	// or a start pixel pair and an end pixel pair (four entries).
	logic [RW-1:0] r1m1;
	logic [AW-1:0] px;
	logic [AW-1:0] pxl;
	logic [AW-1:0] pxe;
	logic [4:0]    sub;
	logic [3:0]    sm;
	logic [3:0]    f0;
	logic [3:0]    f1;
	logic [RW-1:0] span;
	logic          single;

	assign r1m1   = r1_q - RW'(1);
	assign px     = AW'(r0_q >> lgx);
	assign pxl    = AW'(r1m1 >> lgx);
	assign pxe    = AW'(r1_q >> lgx);
	assign sub    = 5'd1 << lgx;
	assign sm     = 4'(sub - 5'd1);
	assign f0     = r0_q[3:0] & sm;
	assign f1     = r1_q[3:0] & sm;
	assign span   = r1_q - r0_q;
	assign single = (px == pxl);

	// Store access: entries never written since the last clear read as zero.
	assign ram_raddr = (state_q == ST_E_RD) ? AW'(pix_q) : upd_addr_q[0];
	assign rd_eff    = rd_vld_q ? ram_rdata : '0;
	assign ram_we    = (state_q == ST_WR);
	assign ram_waddr = upd_addr_q[0];
	assign ram_wdata = rd_eff + upd_amt_q[0];

	sca_ram #(
		.WIDTH (DW),
		.DEPTH (sca_pkg::STORE_DEPTH)
	) u_delta_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Alpha from the clamped prefix sum: round(c * 255 / maxa) with maxa a power of two.
	logic [8:0]  cov;
	logic [16:0] scaled;
	logic [16:0] rounded;
	logic        last_pix;

	assign cov      = acc_q[ACC_W-1] ? 9'd0 :
		((acc_q > $signed({{(ACC_W-9){1'b0}}, maxa})) ? maxa : acc_q[8:0]);
	assign scaled   = {cov, 8'd0} - {8'd0, cov};
	assign rounded  = (scaled + {8'd0, maxa >> 1}) >> lg_sum;
	assign last_pix = ({1'b0, pix_q} == (width - 7'd1));

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lg_x_q      <= 3'd3;
			lg_y_q      <= 3'd3;
			even_odd_q  <= 1'b0;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			row_width_q <= 7'd64;
			winding_q   <= '0;
			prev_x_q    <= '0;
			upd_cnt_q   <= '0;
			vld_q       <= '0;
			pix_q       <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (sca_pkg::cfg_reg_t'(cfg.index))
					sca_pkg::REG_LG_X:      lg_x_q      <= cfg.data[2:0];
					sca_pkg::REG_LG_Y:      lg_y_q      <= cfg.data[2:0];
					sca_pkg::REG_EVEN_ODD:  even_odd_q  <= cfg.data[0];
					sca_pkg::REG_ORIGIN_X:  origin_x_q  <= cfg.data;
					sca_pkg::REG_ORIGIN_Y:  origin_y_q  <= cfg.data;
					sca_pkg::REG_ROW_WIDTH: row_width_q <= cfg.data[6:0];
					default: ;
				endcase
			end

			// A new pixel word may replace the one being taken in the same cycle.
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (dout_take) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (din_acc) begin
						case (in_mode)
							sca_pkg::MODE_CROSSING: begin
								winding_q <= winding_q + (din.crossing_up ? 16'd1 : 16'hFFFF);
								prev_x_q  <= din.crossing_x;
								if (in_shape) begin
									state_q <= ST_CLIP;
								end
							end
							sca_pkg::MODE_SCAN_END, sca_pkg::MODE_FLUSH: begin
								winding_q <= '0;
								prev_x_q  <= left[sca_pkg::COORD_W-1:0];
								if (do_emit) begin
									pix_q   <= '0;
									state_q <= ST_E_RD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CLIP: state_q <= ST_REL;
				ST_REL: begin
					state_q <= (x0_q < x1_q) ? ST_PLAN : ST_IDLE;
				end
				ST_PLAN: begin
					upd_cnt_q <= single ? 3'd2 : 3'd4;
					state_q   <= ST_RD;
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					vld_q[upd_addr_q[0]] <= 1'b1;
					upd_cnt_q <= upd_cnt_q - 3'd1;
					state_q   <= (upd_cnt_q == 3'd1) ? ST_IDLE : ST_RD;
				end
				ST_E_RD: state_q <= ST_E_ACC;
				ST_E_ACC: state_q <= ST_E_OUT;
				ST_E_OUT: begin
					if (out_free) begin
						if (last_pix) begin
							vld_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							pix_q   <= pix_q + sca_pkg::COL_W'(1);
							state_q <= ST_E_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		rd_vld_q <= vld_q[ram_raddr];

		case (state_q)
			ST_IDLE: begin
				x0_q  <= {prev_x_q[sca_pkg::COORD_W-1], prev_x_q};
				x1_q  <= {din.crossing_x[sca_pkg::COORD_W-1], din.crossing_x};
				acc_q <= '0;
				row_q <= y_shr[sca_pkg::ROW_W-1:0] - origin_y_q;
			end
			ST_CLIP: begin
				x0_q <= (x0_q > left) ? x0_q : left;
				x1_q <= (x1_q < right) ? x1_q : right;
			end
			ST_REL: begin
				r0_q <= RW'(x0_q - left);
				r1_q <= RW'(x1_q - left);
			end
			ST_PLAN: begin
				upd_addr_q[0] <= px;
				upd_addr_q[1] <= px + AW'(1);
				if (single) begin
					upd_amt_q[0] <= {1'b0, span};
					upd_amt_q[1] <= -{1'b0, span};
				end else begin
					upd_amt_q[0] <= {7'd0, sub} - {8'd0, f0};
					upd_amt_q[1] <= {8'd0, f0};
				end
				upd_addr_q[2] <= pxe;
				upd_addr_q[3] <= pxe + AW'(1);
				upd_amt_q[2]  <= -({7'd0, sub} - {8'd0, f1});
				upd_amt_q[3]  <= -{8'd0, f1};
			end
			ST_WR: begin
				upd_addr_q[0] <= upd_addr_q[1];
				upd_addr_q[1] <= upd_addr_q[2];
				upd_addr_q[2] <= upd_addr_q[3];
				upd_amt_q[0]  <= upd_amt_q[1];
				upd_amt_q[1]  <= upd_amt_q[2];
				upd_amt_q[2]  <= upd_amt_q[3];
			end
			ST_E_ACC: begin
				acc_q <= acc_q + {{(ACC_W-DW){rd_eff[DW-1]}}, rd_eff};
			end
			ST_E_OUT: begin
				if (out_free) begin
					out_alpha_q <= rounded[7:0];
					out_col_q   <= pix_q;
					out_row_q   <= row_q;
					out_last_q  <= last_pix;
				end
			end
			default: ;
		endcase
	end

	assign dout.valid        = out_vld_q;
	assign dout.alpha        = out_alpha_q;
	assign dout.pixel_column = out_col_q;
	assign dout.pixel_row    = out_row_q;
	assign dout.last_in_row  = out_last_q;

`ifndef SYNTH
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> $past(state_q == ST_RD))
		else $error("store write without a preceding read");

	a_update_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_WR) |-> (upd_cnt_q != 3'd0 && upd_cnt_q <= 3'd4))
		else $error("delta update issued with an empty update list");

	a_store_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_E_OUT && out_free && last_pix) |=> (vld_q == '0))
		else $error("delta store not cleared after a row");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_E_OUT))
		else $error("result word loaded outside row emission");
`endif

endmodule

### tb/sv/sca_coverage_checker.sv
// Checker of the scanline coverage accumulator: watches all channels, predicts pixels, compares.
`timescale 1ns / 100ps

module sca_coverage_checker
	import sca_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	sca_cfg_if   cfg,
	sca_in_if    din,
	sca_out_if   dout,
	output int   fail_count,
	output int   pending,
	output int   pixels_checked
);

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic [COL_W-1:0]   column;
		logic [ROW_W-1:0]   row;
		logic               last;
	} pixel_word_t;

	pixel_word_t        expected_pixels[$];
	logic [DELTA_W-1:0] delta_store [STORE_DEPTH];
	logic [15:0]        winding;
	int                 span_start;

	logic [2:0]         lg_x_reg;
	logic [2:0]         lg_y_reg;
	logic               even_odd_reg;
	logic signed [15:0] origin_x_reg;
	logic signed [15:0] origin_y_reg;
	logic [6:0]         row_width_reg;

	function automatic int lgx_eff();
		return (lg_x_reg > 3'd4) ? 4 : int'(lg_x_reg);
	endfunction

	function automatic int lgy_eff();
		return (lg_y_reg > 3'd4) ? 4 : int'(lg_y_reg);
	endfunction

	function automatic int width_eff();
		if (row_width_reg == 7'd0)
			return 1;
		return (row_width_reg > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : int'(row_width_reg);
	endfunction

	function automatic int window_left();
		return int'(origin_x_reg) * (1 << lgx_eff());
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (fail_count < 40)
			$display("%0t checker: %s got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	task automatic clear_store();
		for (int i = 0; i < STORE_DEPTH; i++)
			delta_store[i] = '0;
	endtask

	task automatic add_delta(int idx, int amount);
		if (idx >= 0 && idx < STORE_DEPTH)
			delta_store[idx] = delta_store[idx] + amount[DELTA_W-1:0];
	endtask

	task automatic finish_scanline();
		winding = '0;
		span_start = window_left();
	endtask

	// Adds the partial-pixel coverage of the span that ends at this crossing.
	task automatic apply_crossing(logic signed [COORD_W-1:0] x_in, logic up);
		int x, left, right, lo, hi, sub, lgx, px, pxl, pxe;
		logic [15:0] wmask;
		lgx = lgx_eff();
		x = x_in;
		left = window_left();
		right = left + (width_eff() << lgx);
		wmask = even_odd_reg ? 16'h0001 : 16'hFFFF;
		if ((winding & wmask) != 16'd0) begin
			lo = (span_start > left) ? span_start : left;
			hi = (x < right) ? x : right;
			if (lo < hi) begin
				sub = 1 << lgx;
				lo -= left;
				hi -= left;
				px = lo >>> lgx;
				pxl = (hi - 1) >>> lgx;
				if (px == pxl) begin
					add_delta(px, hi - lo);
					add_delta(px + 1, lo - hi);
				end else begin
					pxe = hi >>> lgx;
					add_delta(px, sub - (lo & (sub - 1)));
					add_delta(px + 1, lo & (sub - 1));
					add_delta(pxe, (hi & (sub - 1)) - sub);
					add_delta(pxe + 1, -(hi & (sub - 1)));
				end
			end
		end
		winding = up ? winding + 16'd1 : winding - 16'd1;
		span_start = x;
	endtask

	// Prefix-sums the store into one alpha per window pixel, then clears the whole store.
	task automatic emit_row(int y);
		int w, lgx, lgy, maxa, sum, cov;
		logic [ROW_W-1:0] row;
		pixel_word_t pw;
		w = width_eff();
		lgx = lgx_eff();
		lgy = lgy_eff();
		maxa = 1 << (lgx + lgy);
		row = ROW_W'((y >>> lgy) - int'(origin_y_reg));
		sum = 0;
		for (int i = 0; i < w; i++) begin
			sum = sum + $signed(delta_store[i]);
			cov = (sum < 0) ? 0 : ((sum > maxa) ? maxa : sum);
			pw.alpha = ALPHA_W'((cov * 255 + maxa / 2) / maxa);
			pw.column = COL_W'(i);
			pw.row = row;
			pw.last = (i == w - 1);
			expected_pixels.push_back(pw);
		end
		clear_store();
	endtask

	task automatic take_input_word();
		int y, masky;
		logic on_last;
		y = din.scanline_y;
		masky = (1 << lgy_eff()) - 1;
		on_last = ((y & masky) == masky);
		case (mode_t'(din.mode))
			MODE_CROSSING: apply_crossing(din.crossing_x, din.crossing_up);
			MODE_SCAN_END: begin
				finish_scanline();
				if (on_last)
					emit_row(y);
			end
			MODE_FLUSH: begin
				finish_scanline();
				if (!on_last)
					emit_row(y);
			end
			default: ;
		endcase
	endtask

	task automatic take_register_write();
		case (cfg_reg_t'(cfg.index))
			REG_LG_X:      lg_x_reg = cfg.data[2:0];
			REG_LG_Y:      lg_y_reg = cfg.data[2:0];
			REG_EVEN_ODD:  even_odd_reg = cfg.data[0];
			REG_ORIGIN_X:  origin_x_reg = cfg.data;
			REG_ORIGIN_Y:  origin_y_reg = cfg.data;
			REG_ROW_WIDTH: row_width_reg = cfg.data[6:0];
			default: ;
		endcase
	endtask

	task automatic check_pixel_word();
		pixel_word_t want;
		if (expected_pixels.size() == 0) begin
			report_mismatch("pixel word with none outstanding, alpha", dout.alpha, 0);
		end else begin
			want = expected_pixels.pop_front();
			if (dout.alpha !== want.alpha)
				report_mismatch("alpha", dout.alpha, want.alpha);
			if (dout.pixel_column !== want.column)
				report_mismatch("pixel_column", dout.pixel_column, want.column);
			if (dout.pixel_row !== want.row)
				report_mismatch("pixel_row", dout.pixel_row, want.row);
			if (dout.last_in_row !== want.last)
				report_mismatch("last_in_row", dout.last_in_row, want.last);
			pixels_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_x_reg = 3'd3;
			lg_y_reg = 3'd3;
			even_odd_reg = 1'b0;
			origin_x_reg = '0;
			origin_y_reg = '0;
			row_width_reg = 7'd64;
			clear_store();
			finish_scanline();
			expected_pixels.delete();
			fail_count = 0;
			pixels_checked = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				take_register_write();
			if (din.valid && din.ready)
				take_input_word();
			if (dout.valid && dout.ready)
				check_pixel_word();
			pending = expected_pixels.size();
		end
	end

endmodule

### tb/sv/tb_scanline_coverage_accumulator_top.sv
// Top of the scanline coverage accumulator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_scanline_coverage_accumulator_top;
	import sca_pkg::*;

	// With nothing accepted on any channel for this many cycles the run is declared hung.
	// The longest legal quiet stretch is the receiver hold-off below plus a row in flight.
	localparam int IDLE_LIMIT      = 4000;
	// Length of the receiver hold-off that makes the block back up into its input.
	localparam int HOLD_OFF_CYCLES = 700;
	// A crossing inside the shape produces no pixel word and may still be in flight, so
	// before a register write we give the block this long after the last pixel word.
	localparam int SETTLE_CYCLES   = 16;
	localparam int TAIL_CYCLES     = 48;
	localparam int PHASES          = 12;
	localparam int PHASE_WORDS     = 36;
	localparam int COORD_MAX       = (1 << (COORD_W - 1)) - 1;
	localparam int COORD_MIN       = -(1 << (COORD_W - 1));
	// An index past the last register; the block must accept the write and ignore it.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

	logic clk = 1'b0;
	logic arst_n;

	sca_cfg_if cfg_ch ();
	sca_in_if  in_ch ();
	sca_out_if out_ch ();

	int fail_count;
	int pending;
	int pixels_checked;

	// Sender and receiver both see these: a quiet phase turns idling off on both sides,
	// and a pressure request asks the receiver for one long hold-off.
	logic quiet_phase;
	logic pressure_request;

	int words_sent;
	int reg_writes;
	int settings_used;
	int idle_cycles;

	// Shadow of the effective configuration, used only to aim the stimulus at the window.
	int stim_lgx;
	int stim_lgy;
	int stim_width;
	int stim_left;
	int stim_top;
	int scan_y;

	scanline_coverage_accumulator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.din    (in_ch),
		.dout   (out_ch)
	);

	sca_coverage_checker coverage_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_ch),
		.din            (in_ch),
		.dout           (out_ch),
		.fail_count     (fail_count),
		.pending        (pending),
		.pixels_checked (pixels_checked)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly back-to-back, sometimes a short pause, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic int clamp_coord(int v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	// Any 21-bit signed value, so every bit of a coordinate field gets exercised.
	function automatic int rand_coord();
		int v;
		v = $urandom_range(0, (1 << COORD_W) - 1);
		return v + COORD_MIN;
	endfunction

	function automatic int rand_origin();
		int v;
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, 100) - 50;
		v = $urandom_range(0, 65535);
		return v - 32768;
	endfunction

	// Offers one word after a random gap (none in quiet phases) and holds it until the block takes it.
	// Inputs only ever change at the falling edge.
	task automatic send_word(mode_t m, int x, logic up, int y);
		int gap;
		gap = quiet_phase ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.mode = m;
		in_ch.crossing_x = x[COORD_W-1:0];
		in_ch.crossing_up = up;
		in_ch.scanline_y = y[COORD_W-1:0];
		do @(posedge clk); while (!in_ch.ready);
		if (m != MODE_UNUSED)
			words_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Registers change only here, always with the block drained.
	task automatic configure(int lgx, int lgy, int eo, int ox, int oy, int rw);
		write_reg(REG_LG_X, lgx);
		write_reg(REG_LG_Y, lgy);
		write_reg(REG_EVEN_ODD, eo);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ROW_WIDTH, rw);
		stim_lgx = (lgx > 4) ? 4 : lgx;
		stim_lgy = (lgy > 4) ? 4 : lgy;
		stim_width = (rw == 0) ? 1 : ((rw > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : rw);
		stim_left = ox * (1 << stim_lgx);
		stim_top = oy * (1 << stim_lgy);
		settings_used++;
	endtask

	// Drops valid, waits for every predicted pixel word, then lets in-flight crossings finish.
	task automatic drain_block();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One subpixel scanline: crossings in ascending x (or scattered when unsorted is set),
	// then its end word. Rows come out whenever scan_y reaches the last subpixel line.
	task automatic send_scanline(logic unsorted);
		int k, x, sub, span;
		sub = 1 << stim_lgx;
		span = (stim_width + 4) * sub;
		k = unsorted ? $urandom_range(1, 4) : 2 * $urandom_range(0, 3);
		if (!unsorted && $urandom_range(0, 9) == 0)
			k++;
		x = stim_left - $urandom_range(0, 2 * sub);
		for (int i = 0; i < k; i++) begin
			if (unsorted)
				x = stim_left - 2 * sub + $urandom_range(0, span);
			else
				x = x + $urandom_range(0, (stim_width * sub) / 2 + sub);
			send_word(MODE_CROSSING, clamp_coord(x), 1'($urandom_range(0, 1)), rand_coord());
		end
		send_word(MODE_SCAN_END, rand_coord(), 1'($urandom_range(0, 1)), clamp_coord(scan_y));
		scan_y = (scan_y >= COORD_MAX) ? COORD_MIN : scan_y + 1;
	endtask

	// The receiver: random stalls, none in quiet phases, and one long hold-off on request.
	// The hold-off is counted here so the sender keeps offering words meanwhile.
	initial begin : result_sink
		int stall;
		logic held_off;
		stall = 0;
		held_off = 1'b0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (pressure_request && !held_off) begin
				held_off = 1'b1;
				out_ch.ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else if (stall > 0) begin
				out_ch.ready = 1'b0;
				stall--;
			end else if (quiet_phase) begin
				out_ch.ready = 1'b1;
			end else begin
				stall = pick_gap();
				out_ch.ready = (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	// Watchdog: counts cycles in which no channel moves a word.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d pixel words outstanding",
				IDLE_LIMIT, pending);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		int first_word, r, lgx, lgy, eo, ox, oy, rw;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_CROSSING;
		in_ch.crossing_x = '0;
		in_ch.crossing_up = 1'b0;
		in_ch.scanline_y = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_LG_X;
		cfg_ch.data = '0;
		quiet_phase = 1'b0;
		pressure_request = 1'b0;
		words_sent = 0;
		reg_writes = 0;
		settings_used = 1;
		stim_lgx = 3;
		stim_lgy = 3;
		stim_width = MAX_ROW_WIDTH;
		stim_left = 0;
		stim_top = 0;
		scan_y = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, on the reset configuration: 8x8 subsamples, nonzero rule,
		// a 64-pixel window at the origin.
		// The extremes of x: the span is clipped to the whole window on both sides.
		send_word(MODE_CROSSING, COORD_MIN, 1'b1, rand_coord());
		send_word(MODE_CROSSING, COORD_MAX, 1'b0, rand_coord());
		// A scanline end that is not the last subpixel line emits nothing.
		send_word(MODE_SCAN_END, rand_coord(), 1'b0, 0);
		// A span inside one pixel, then spans across pixels with a negative winding count.
		send_word(MODE_CROSSING, 3, 1'b1, rand_coord());
		send_word(MODE_CROSSING, 5, 1'b0, rand_coord());
		send_word(MODE_CROSSING, 10, 1'b0, rand_coord());
		send_word(MODE_CROSSING, 30, 1'b0, rand_coord());
		send_word(MODE_CROSSING, 44, 1'b1, rand_coord());
		send_word(MODE_CROSSING, 50, 1'b1, rand_coord());
		// The unused mode is ignored whatever its fields carry.
		send_word(MODE_UNUSED, rand_coord(), 1'b1, rand_coord());
		// Crossings out of order: the span runs backward and adds nothing.
		send_word(MODE_CROSSING, 100, 1'b1, rand_coord());
		send_word(MODE_CROSSING, 20, 1'b0, rand_coord());
		send_word(MODE_SCAN_END, rand_coord(), 1'b1, 6);
		// A flush in mid row emits it; a flush on the last subpixel line does not.
		send_word(MODE_FLUSH, rand_coord(), 1'b0, 2);
		send_word(MODE_FLUSH, rand_coord(), 1'b1, 15);
		// A span clipped at the right edge, closed on a negative y that wraps the row.
		send_word(MODE_CROSSING, 1, 1'b1, rand_coord());
		send_word(MODE_CROSSING, 600, 1'b0, rand_coord());
		send_word(MODE_SCAN_END, rand_coord(), 1'b0, -1);
		// The extremes of y, on an empty store.
		send_word(MODE_SCAN_END, rand_coord(), 1'b1, COORD_MAX);
		send_word(MODE_FLUSH, rand_coord(), 1'b0, COORD_MIN);
		drain_block();

		// Even-odd rule on a small window left of the origin: only odd counts fill.
		configure(2, 1, 1, -3, 5, 5);
		send_word(MODE_CROSSING, -20, 1'b1, rand_coord());
		send_word(MODE_CROSSING, -6, 1'b1, rand_coord());
		send_word(MODE_CROSSING, 0, 1'b1, rand_coord());
		send_word(MODE_CROSSING, 8, 1'b0, rand_coord());
		send_word(MODE_SCAN_END, rand_coord(), 1'b1, 11);
		drain_block();

		// Random phases, each on its own configuration. The first few hit the extremes:
		// one sample per pixel, the largest subsample counts, the saturating shift values,
		// the window at both ends of its range and row widths of zero and past the maximum.
		for (int p = 0; p < PHASES; p++) begin
			lgx = $urandom_range(0, 7);
			lgy = $urandom_range(0, 7);
			eo = $urandom_range(0, 1);
			ox = rand_origin();
			oy = rand_origin();
			r = $urandom_range(0, 99);
			rw = (r < 70) ? $urandom_range(1, 16) :
				((r < 90) ? $urandom_range(17, 63) : MAX_ROW_WIDTH);
			case (p)
				0: begin
					lgx = 0; lgy = 0; eo = 0; ox = 0; oy = 0; rw = 1;
				end
				1: begin
					lgx = 4; lgy = 4; eo = 1; ox = -32768; oy = 32767; rw = MAX_ROW_WIDTH;
				end
				2: begin
					lgx = 7; lgy = 5; eo = 0; ox = 32767; oy = -32768; rw = 0;
				end
				3: begin
					// Every scanline end emits a full row; the receiver holds off once in this phase.
					lgx = 2; lgy = 0; rw = MAX_ROW_WIDTH;
				end
				4: rw = 127;
				5: begin
					lgx = 6; lgy = 7; rw = MAX_ROW_WIDTH + 1;
				end
				default: ;
			endcase
			configure(lgx, lgy, eo, ox, oy, rw);
			if (p == 6) begin
				write_reg(REG_SPARE, $urandom_range(0, 65535));
				drain_block();
			end

			// Some phases run without any idling, the pressure phase among them so the
			// sender keeps offering words while the receiver sits still.
			quiet_phase = (p % 4 == 3) || (p == 8);
			if (p == 3)
				pressure_request = 1'b1;
			scan_y = clamp_coord(stim_top + $urandom_range(0, 3));
			first_word = words_sent;
			while (words_sent - first_word < PHASE_WORDS) begin
				r = $urandom_range(0, 99);
				if (r < 75 || p == 3) begin
					send_scanline(1'b0);
				end else if (r < 85) begin
					send_scanline(1'b1);
				end else if (r < 90) begin
					send_word(MODE_FLUSH, rand_coord(), 1'($urandom_range(0, 1)),
						clamp_coord(scan_y));
				end else if (r < 95) begin
					send_word(MODE_UNUSED, rand_coord(), 1'($urandom_range(0, 1)), rand_coord());
				end else begin
					send_word(MODE_CROSSING, rand_coord(), 1'($urandom_range(0, 1)),
						rand_coord());
				end
				if ($urandom_range(0, 24) == 0)
					scan_y = rand_coord();
			end
			send_word(MODE_FLUSH, rand_coord(), 1'($urandom_range(0, 1)), clamp_coord(scan_y));
			drain_block();
			quiet_phase = 1'b0;
		end

		// All words are in and every predicted pixel word has come back; give the block
		// time to show any stray output before the verdict.
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("summary: %0d input words over %0d register settings (%0d register writes)",
			words_sent, settings_used, reg_writes);
		$display("summary: %0d pixel words compared, one receiver hold-off of %0d cycles",
			pixels_checked, HOLD_OFF_CYCLES);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### sim.f
rtl/sca_pkg.sv
rtl/sca_if.sv
rtl/sca_ram.sv
rtl/scanline_coverage_accumulator_top.sv
tb/sv/sca_coverage_checker.sv
tb/sv/tb_scanline_coverage_accumulator_top.sv
